// ===== rtl/per_pixel_kalman_range_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Per-pixel Kalman range filter: assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PER_PIXEL_KALMAN_RANGE_FILTER_ASSERT_SVH
`define PER_PIXEL_KALMAN_RANGE_FILTER_ASSERT_SVH

// same-cycle implication
`define PPKRF_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ppkrf check failed");

// next-cycle implication
`define PPKRF_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ppkrf check failed");

`endif

// ===== rtl/ppkrf_pkg.sv =====
// ----------------------------------------------------------------------------
// Per-pixel Kalman range filter package
// Transfer types, register codes and shared constants.
// ----------------------------------------------------------------------------
package ppkrf_pkg;

  localparam int unsigned PIXEL_COUNT_DEF = 65536;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned FIFO_DEPTH      = 32;
  localparam int unsigned GAIN_W          = 16;

  localparam logic [23:0] PROCESS_NOISE_RST     = 24'd256;
  localparam logic [23:0] MEASUREMENT_NOISE_RST = 24'd2304;

  // register codes
  typedef enum logic [0:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] pixel_index;
    logic [19:0] range_mm;
  } in_t;

  typedef struct packed {
    logic [15:0] out_pixel_index;
    logic [19:0] filtered_range_mm;
  } out_t;

endpackage

// ===== rtl/ppkrf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, registered read data, read-first.
// ----------------------------------------------------------------------------
module ppkrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/per_pixel_kalman_range_filter.sv =====
// ----------------------------------------------------------------------------
// Per-pixel Kalman range filter
// Keeps a scalar Kalman filter per pixel in RAM; read, update, write back.
// ----------------------------------------------------------------------------
//  channel   ports                       role
//  in        in_valid/in_ready/in_data   pixel index and raw range
//  out       out_valid/out_ready/out_data pixel index and filtered range
//  cfg       psel..pready                process and measurement noise
//
//  one transfer per cycle while in_ready; results pass a, b, divider, m, queue
//  the gain divider is 16 pipelined restoring steps, one quotient bit a stage
//  after reset a clearing pass over all PIXEL_COUNT entries wipes the started flags
//  an input for a pixel still in flight waits until its write-back is done
//  in_ready drops while 32 transfers are in flight or queued at the output
// ----------------------------------------------------------------------------
`include "per_pixel_kalman_range_filter_assert.svh"

module per_pixel_kalman_range_filter #(
  parameter int unsigned PIXEL_COUNT = ppkrf_pkg::PIXEL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ppkrf_pkg::in_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ppkrf_pkg::out_t                out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppkrf_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ppkrf_pkg::*;

  localparam int unsigned AW   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned PW   = $clog2(FIFO_DEPTH);
  localparam int unsigned NDIV = GAIN_W;

  typedef struct packed {
    logic        ok;
    logic [15:0] idx;
    logic [27:0] target;
  } a_t;

  typedef struct packed {
    logic        ok;
    logic        first;
    logic [15:0] idx;
    logic [27:0] target;
    logic [27:0] est;
    logic [31:0] p;
  } b_t;

  typedef struct packed {
    logic        ok;
    logic        first;
    logic [15:0] idx;
    logic [27:0] target;
    logic [27:0] est;
    logic [31:0] p;
    logic [32:0] den;
    logic [32:0] rem;
    logic [15:0] quo;
  } dv_t;

  typedef struct packed {
    logic        ok;
    logic        first;
    logic [15:0] idx;
    logic [27:0] target;
    logic [27:0] est;
    logic        up;
    logic [43:0] prod_e;
    logic [48:0] prod_v;
  } m_t;

  // one restoring division step
  function automatic dv_t div_step(input dv_t s);
    dv_t         o;
    logic [33:0] r2;
    logic [33:0] diff;
    o    = s;
    r2   = {s.rem, 1'b0};
    diff = r2 - {1'b0, s.den};
    if (r2 >= {1'b0, s.den}) begin
      o.rem = diff[32:0];
      o.quo = {s.quo[14:0], 1'b1};
    end else begin
      o.rem = r2[32:0];
      o.quo = {s.quo[14:0], 1'b0};
    end
    return o;
  endfunction

  // configuration registers
  logic [23:0] q_r;
  logic [23:0] r_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= PROCESS_NOISE_RST;
      r_r <= MEASUREMENT_NOISE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PROCESS_NOISE:     q_r <= pwdata[23:0];
        REG_MEASUREMENT_NOISE: r_r <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PROCESS_NOISE:     prdata = {8'd0, q_r};
      REG_MEASUREMENT_NOISE: prdata = {8'd0, r_r};
    endcase
  end

  // pipeline registers
  logic            a_v_r, b_v_r, m_v_r;
  logic [NDIV:0]   dv_v_r;
  a_t              a_r;
  b_t              b_r;
  dv_t             dv_r [NDIV+1];
  m_t              m_r;

  // clearing pass and occupancy
  logic            clr_busy_r;
  logic [AW-1:0]   clr_cnt_r;
  logic [PW:0]     cnt_r;
  logic [PW:0]     fifo_cnt_r;
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  out_t            fifo_mem_r [FIFO_DEPTH];

  // input decode
  logic [31:0]     in_idx_ext;
  logic            in_ok;
  logic            hz;
  logic            in_acc;
  logic            pop;

  assign in_idx_ext = 32'(in_data.pixel_index);
  assign in_ok      = (in_idx_ext < 32'(PIXEL_COUNT)) && (in_data.range_mm != 20'd0);

  // same-pixel interlock against every in-flight writer
  always_comb begin
    hz = (a_v_r && a_r.ok && a_r.idx == in_data.pixel_index) ||
         (b_v_r && b_r.ok && b_r.idx == in_data.pixel_index) ||
         (m_v_r && m_r.ok && m_r.idx == in_data.pixel_index);
    for (int k = 0; k <= NDIV; k++) begin
      if (dv_v_r[k] && dv_r[k].ok && dv_r[k].idx == in_data.pixel_index) begin
        hz = 1'b1;
      end
    end
  end

  assign in_ready = !clr_busy_r && (cnt_r < (PW+1)'(FIFO_DEPTH)) && !hz;
  assign in_acc   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // state memories
  logic [28:0]     est_rd;
  logic [31:0]     var_rd;
  logic            est_we, wr_en;
  logic [AW-1:0]   wr_addr, est_waddr;
  logic [28:0]     est_wdata;
  logic [27:0]     est_w;
  logic [31:0]     var_w;
  logic [31:0]     m_idx_ext;

  assign m_idx_ext = 32'(m_r.idx);
  assign wr_addr   = m_idx_ext[AW-1:0];
  assign wr_en     = m_v_r && m_r.ok;
  assign est_we    = clr_busy_r || wr_en;
  assign est_waddr = clr_busy_r ? clr_cnt_r : wr_addr;
  assign est_wdata = clr_busy_r ? 29'd0 : {1'b1, est_w};

  ppkrf_ram #(.WIDTH(29), .DEPTH(PIXEL_COUNT), .AW(AW)) u_est_ram (
    .clk   (clk),
    .we    (est_we),
    .waddr (est_waddr),
    .wdata (est_wdata),
    .raddr (in_idx_ext[AW-1:0]),
    .rdata (est_rd)
  );

  ppkrf_ram #(.WIDTH(32), .DEPTH(PIXEL_COUNT), .AW(AW)) u_var_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (var_w),
    .raddr (in_idx_ext[AW-1:0]),
    .rdata (var_rd)
  );

  // predict: add process noise, saturate
  logic [32:0] p_sum;
  logic [31:0] p_sat;
  assign p_sum = {1'b0, var_rd} + 33'(q_r);
  assign p_sat = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];

  // divider front end
  dv_t dv_in;
  always_comb begin
    dv_in.ok     = b_r.ok;
    dv_in.first  = b_r.first;
    dv_in.idx    = b_r.idx;
    dv_in.target = b_r.target;
    dv_in.est    = b_r.est;
    dv_in.p      = b_r.p;
    dv_in.den    = {1'b0, b_r.p} + 33'(r_r);
    dv_in.rem    = {1'b0, b_r.p};
    dv_in.quo    = '0;
  end

  // gain and products
  logic [15:0] gain;
  logic        up;
  logic [27:0] dmag;
  logic [16:0] omg;
  assign gain = (r_r == 24'd0) ? 16'hFFFF : dv_r[NDIV].quo;
  assign up   = dv_r[NDIV].target >= dv_r[NDIV].est;
  assign dmag = up ? (dv_r[NDIV].target - dv_r[NDIV].est)
                   : (dv_r[NDIV].est - dv_r[NDIV].target);
  assign omg  = 17'h10000 - {1'b0, gain};

  // update and write-back values
  logic [43:0] dec_sum;
  always_comb begin
    dec_sum = m_r.prod_e + 44'h000_0000_FFFF;
    if (m_r.first) begin
      est_w = m_r.target;
      var_w = 32'(r_r);
    end else begin
      est_w = m_r.up ? (m_r.est + m_r.prod_e[43:16]) : (m_r.est - dec_sum[43:16]);
      var_w = m_r.prod_v[47:16];
    end
  end

  out_t res;
  assign res.out_pixel_index   = m_r.idx;
  assign res.filtered_range_mm = m_r.ok ? est_w[27:8] : 20'd0;

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      dv_v_r <= '0;
      m_v_r  <= 1'b0;
    end else begin
      a_v_r  <= in_acc;
      b_v_r  <= a_v_r;
      dv_v_r <= {dv_v_r[NDIV-1:0], b_v_r};
      m_v_r  <= dv_v_r[NDIV];
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    a_r.ok     <= in_ok;
    a_r.idx    <= in_data.pixel_index;
    a_r.target <= {in_data.range_mm, 8'd0};

    b_r.ok     <= a_r.ok;
    b_r.first  <= !est_rd[28];
    b_r.idx    <= a_r.idx;
    b_r.target <= a_r.target;
    b_r.est    <= est_rd[28] ? est_rd[27:0] : a_r.target;
    b_r.p      <= p_sat;

    dv_r[0] <= dv_in;
    for (int k = 0; k < NDIV; k++) begin
      dv_r[k+1] <= div_step(dv_r[k]);
    end

    m_r.ok     <= dv_r[NDIV].ok;
    m_r.first  <= dv_r[NDIV].first;
    m_r.idx    <= dv_r[NDIV].idx;
    m_r.target <= dv_r[NDIV].target;
    m_r.est    <= dv_r[NDIV].est;
    m_r.up     <= up;
    m_r.prod_e <= {16'd0, dmag} * {28'd0, gain};
    m_r.prod_v <= {17'd0, dv_r[NDIV].p} * {32'd0, omg};
  end

  // clearing pass and occupancy counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      cnt_r      <= '0;
      fifo_cnt_r <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(PIXEL_COUNT - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      cnt_r      <= cnt_r + (PW+1)'(in_acc) - (PW+1)'(pop);
      fifo_cnt_r <= fifo_cnt_r + (PW+1)'(m_v_r) - (PW+1)'(pop);
      if (m_v_r) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (m_v_r) begin
      fifo_mem_r[wr_ptr_r] <= res;
    end
  end

  assign out_valid = fifo_cnt_r != '0;
  assign out_data  = fifo_mem_r[rd_ptr_r];

  // checks
  `PPKRF_ASSERT_IMP(a_no_overflow, m_v_r && !pop, fifo_cnt_r < (PW+1)'(FIFO_DEPTH))
  `PPKRF_ASSERT_IMP(a_no_acc_in_clear, in_acc, !clr_busy_r)
  `PPKRF_ASSERT_IMP(a_no_raw_hazard, in_acc && m_v_r && m_r.ok, m_r.idx != in_data.pixel_index)
  `PPKRF_ASSERT_NXT(a_cnt_covers_fifo, 1'b1, cnt_r >= fifo_cnt_r)

endmodule
